// File: src/mpeg_audio_frame_header_decode_top_macros.svh
// Assertion macros for the MPEG audio frame header decoder.
`ifndef MPEG_AUDIO_FRAME_HEADER_DECODE_TOP_MACROS_SVH
`define MPEG_AUDIO_FRAME_HEADER_DECODE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MAFHD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MAFHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mafhd_pkg.sv
// Package: widths, code names, lookup tables and stage records of the header decoder.
`default_nettype none
package mafhd_pkg;

  // Quotient bits (one per divider cell), dividend and divisor widths
  localparam int QuoW = 12;
  localparam int DvdW = 26;
  localparam int DsrW = 16;

  // Layer codes as they appear in the header
  localparam logic [1:0] LcodeRsvd = 2'd0;
  localparam logic [1:0] LcodeL3   = 2'd1;
  localparam logic [1:0] LcodeL2   = 2'd2;
  localparam logic [1:0] LcodeL1   = 2'd3;

  // Version codes
  localparam logic [1:0] VcodeMpeg25 = 2'd0;
  localparam logic [1:0] VcodeRsvd   = 2'd1;
  localparam logic [1:0] VcodeMpeg2  = 2'd2;
  localparam logic [1:0] VcodeMpeg1  = 2'd3;

  localparam logic [1:0] SidxRsvd = 2'd3;
  localparam logic [3:0] BidxBad  = 4'd15;

  localparam logic [17:0] MulL23 = 18'd144000;
  localparam logic [17:0] MulL1  = 18'd12000;

  localparam logic [10:0] SpfL1    = 11'd384;
  localparam logic [10:0] SpfL3Lsf = 11'd576;
  localparam logic [10:0] SpfFull  = 11'd1152;

  localparam logic [15:0] Sr44k = 16'd44100;
  localparam logic [15:0] Sr48k = 16'd48000;
  localparam logic [15:0] Sr32k = 16'd32000;

  // Bitrate tables in kbit/s, index 15 is the bad index and its entry is never used
  localparam logic [8:0] BrM1L1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] BrM1L2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] BrM1L3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] BrLsfL1 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] BrLsfL23 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  // Look up the bitrate for one version class, layer code and index
  function automatic logic [8:0] br_lookup(input logic lsf, input logic [1:0] lcode,
                                           input logic [3:0] bidx);
    logic [8:0] br;
    br = 9'd0;
    if (lsf) begin
      if (lcode == LcodeL1) br = BrLsfL1[bidx];
      else                  br = BrLsfL23[bidx];
    end else begin
      case (lcode)
        LcodeL1: br = BrM1L1[bidx];
        LcodeL2: br = BrM1L2[bidx];
        LcodeL3: br = BrM1L3[bidx];
        default: br = 9'd0;
      endcase
    end
    return br;
  endfunction

  // Base sample rate for the MPEG-1 index
  function automatic logic [15:0] sr_base(input logic [1:0] sidx);
    logic [15:0] sr;
    case (sidx)
      2'd0:    sr = Sr44k;
      2'd1:    sr = Sr48k;
      2'd2:    sr = Sr32k;
      default: sr = 16'd0;
    endcase
    return sr;
  endfunction

  // Division state carried from cell to cell
  typedef struct packed {
    logic [DsrW-1:0] rem;   // partial remainder, always below dsr
    logic [QuoW-1:0] dlo;   // dividend bits still to shift in, MSB first
    logic [QuoW-1:0] quo;   // quotient bits so far
    logic [DsrW-1:0] dsr;   // divisor (sample rate)
  } div_t;

  // Result fields riding along with the division
  typedef struct packed {
    logic        valid_res;
    logic [15:0] srate_hz;
    logic [10:0] samples_per_frame;
    logic [8:0]  bitrate_kbps;
    logic        pad;
    logic        layer1;
    logic        halve;
  } side_t;

endpackage
`default_nettype wire

// File: src/mafhd_if.sv
// Handshake interfaces for header words in and decoded results out.
`default_nettype none
interface mafhd_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] header_bits;

  modport source (output valid, output header_bits, input ready);
  modport sink   (input valid, input header_bits, output ready);
endinterface

interface mafhd_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [15:0] srate_hz;
  logic [11:0] frame_bytes;
  logic [10:0] samples_per_frame;
  logic [8:0]  bitrate_kbps;

  modport source (output valid, output valid_res, output srate_hz, output frame_bytes,
                  output samples_per_frame, output bitrate_kbps, input ready);
  modport sink   (input valid, input valid_res, input srate_hz, input frame_bytes,
                  input samples_per_frame, input bitrate_kbps, output ready);
endinterface
`default_nettype wire

// File: src/mafhd_decode.sv
// Field decode, table lookups and dividend product; first stage of the chain.
`default_nettype none
module mafhd_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                hdr_vld,
  input  logic [23:0]         header_bits,
  output logic                vld,
  output mafhd_pkg::div_t     div,
  output mafhd_pkg::side_t    side
);

  logic [1:0]  vcode, lcode, sidx;
  logic [3:0]  bidx;
  logic        pad, ok, lsf, l1, l3;
  logic [1:0]  shift;
  logic [8:0]  br;
  logic [15:0] sr;
  logic [17:0] mul_k;
  logic [mafhd_pkg::DvdW-1:0] prod;
  mafhd_pkg::div_t  div_next;
  mafhd_pkg::side_t side_next;

  // Split the header and decode the codes
  always_comb begin
    vcode = header_bits[20:19];
    lcode = header_bits[18:17];
    bidx  = header_bits[15:12];
    sidx  = header_bits[11:10];
    pad   = header_bits[9];
    ok    = (lcode != mafhd_pkg::LcodeRsvd) && (sidx != mafhd_pkg::SidxRsvd)
            && (bidx != mafhd_pkg::BidxBad);
    case (vcode)
      mafhd_pkg::VcodeMpeg1:  shift = 2'd0;
      mafhd_pkg::VcodeMpeg2:  shift = 2'd1;
      mafhd_pkg::VcodeMpeg25: shift = 2'd2;
      mafhd_pkg::VcodeRsvd:   shift = 2'd2;
      default:                shift = 2'd2;
    endcase
    lsf   = (shift != 2'd0);
    l1    = (lcode == mafhd_pkg::LcodeL1);
    l3    = (lcode == mafhd_pkg::LcodeL3);
    br    = mafhd_pkg::br_lookup(lsf, lcode, bidx);
    sr    = mafhd_pkg::sr_base(sidx) >> shift;
    mul_k = l1 ? mafhd_pkg::MulL1 : mafhd_pkg::MulL23;
    prod  = mafhd_pkg::DvdW'(br) * mafhd_pkg::DvdW'(mul_k);
  end

  // Build the initial division state and the side fields; zero them when illegal, divisor set to one
  always_comb begin
    div_next  = '0;
    side_next = '0;
    div_next.dsr = mafhd_pkg::DsrW'(1);
    if (ok) begin
      div_next.rem = mafhd_pkg::DsrW'(prod[mafhd_pkg::DvdW-1:mafhd_pkg::QuoW]);
      div_next.dlo = prod[mafhd_pkg::QuoW-1:0];
      div_next.dsr = sr;
      side_next.valid_res   = 1'b1;
      side_next.srate_hz    = sr;
      side_next.bitrate_kbps = br;
      side_next.pad    = pad;
      side_next.layer1 = l1;
      side_next.halve  = l3 && lsf;
      if (l1)            side_next.samples_per_frame = mafhd_pkg::SpfL1;
      else if (l3 && lsf) side_next.samples_per_frame = mafhd_pkg::SpfL3Lsf;
      else               side_next.samples_per_frame = mafhd_pkg::SpfFull;
    end
  end

  // Hold while the chain stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= hdr_vld;
    end
    if (en) begin
      div  <= div_next;
      side <= side_next;
    end
  end

endmodule
`default_nettype wire

// File: src/mafhd_div_cell.sv
// One restoring division cell: produces one quotient bit and hands on the rest.
`default_nettype none
module mafhd_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                prev_vld,
  input  mafhd_pkg::div_t     prev_div,
  input  mafhd_pkg::side_t    prev_side,
  output logic                vld,
  output mafhd_pkg::div_t     div,
  output mafhd_pkg::side_t    side
);

  logic [mafhd_pkg::DsrW:0]   trial;
  logic [mafhd_pkg::DsrW:0]   diff;
  logic                       ge;
  mafhd_pkg::div_t            div_next;

  // Shift in the next dividend bit and subtract the divisor if it fits
  always_comb begin
    trial = {prev_div.rem, prev_div.dlo[mafhd_pkg::QuoW-1]};
    diff  = trial - {1'b0, prev_div.dsr};
    ge    = (trial >= {1'b0, prev_div.dsr});
    div_next     = prev_div;
    div_next.rem = ge ? diff[mafhd_pkg::DsrW-1:0] : trial[mafhd_pkg::DsrW-1:0];
    div_next.dlo = {prev_div.dlo[mafhd_pkg::QuoW-2:0], 1'b0};
    div_next.quo = {prev_div.quo[mafhd_pkg::QuoW-2:0], ge};
  end

  // Advance to the neighbor cell when the chain moves
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= prev_vld;
    end
    if (en) begin
      div  <= div_next;
      side <= prev_side;
    end
  end

endmodule
`default_nettype wire

// File: src/mpeg_audio_frame_header_decode_top.sv
// Top level of the MPEG audio frame header decoder: decode, divider chain, result register.
//
//  Port     Dir  Fields                                          Meaning
//  hdr_in   in   header_bits[23:0]                               header bytes 1..3
//  res_out  out  valid_res, srate_hz, frame_bytes,               decoded frame data
//                samples_per_frame, bitrate_kbps
//
// One header word enters per cycle unless a waiting result stalls the chain; each result
// passes the decode stage, twelve divider cells and the result register. The twelve-cell
// restoring divider chain forms the frame size.
// Reset clears the valid bits of every stage; payload registers are not reset.
// When a result waits untaken, the whole chain holds and hdr_in.ready drops.
`default_nettype none
`include "mpeg_audio_frame_header_decode_top_macros.svh"
module mpeg_audio_frame_header_decode_top (
  input logic          clk,
  input logic          rst,
  mafhd_in_if.sink     hdr_in,
  mafhd_out_if.source  res_out
);

  localparam int Cells = mafhd_pkg::QuoW;

  logic                 adv;
  logic                 stage_vld  [Cells+1];
  mafhd_pkg::div_t      stage_div  [Cells+1];
  mafhd_pkg::side_t     stage_side [Cells+1];

  logic                 out_vld;
  logic                 valid_res;
  logic [15:0]          srate_hz;
  logic [11:0]          frame_bytes;
  logic [10:0]          samples_per_frame;
  logic [8:0]           bitrate_kbps;

  logic [mafhd_pkg::QuoW-1:0] q_half;
  logic [11:0]                size_sum;
  logic [11:0]                size_next;

  // Move the chain whenever the result register is free or being taken
  assign adv          = !out_vld || res_out.ready;
  assign hdr_in.ready = adv;

  mafhd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .hdr_vld     (hdr_in.valid),
    .header_bits (hdr_in.header_bits),
    .vld         (stage_vld[0]),
    .div         (stage_div[0]),
    .side        (stage_side[0])
  );

  // Row of divider cells, one quotient bit each
  for (genvar i = 0; i < Cells; i++) begin : g_cell
    mafhd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .prev_vld  (stage_vld[i]),
      .prev_div  (stage_div[i]),
      .prev_side (stage_side[i]),
      .vld       (stage_vld[i+1]),
      .div       (stage_div[i+1]),
      .side      (stage_side[i+1])
    );
  end

  // Finish the frame size: halve for low-rate layer 3, add padding, scale layer 1 slots
  always_comb begin
    q_half    = stage_side[Cells].halve ?
                {1'b0, stage_div[Cells].quo[mafhd_pkg::QuoW-1:1]} : stage_div[Cells].quo;
    size_sum  = 12'(q_half) + 12'(stage_side[Cells].pad);
    size_next = stage_side[Cells].layer1 ? {size_sum[9:0], 2'b00} : size_sum;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= stage_vld[Cells];
    end
    if (adv) begin
      valid_res         <= stage_side[Cells].valid_res;
      srate_hz          <= stage_side[Cells].srate_hz;
      samples_per_frame <= stage_side[Cells].samples_per_frame;
      bitrate_kbps      <= stage_side[Cells].bitrate_kbps;
      frame_bytes       <= size_next;
    end
  end

  assign res_out.valid             = out_vld;
  assign res_out.valid_res         = valid_res;
  assign res_out.srate_hz          = srate_hz;
  assign res_out.frame_bytes       = frame_bytes;
  assign res_out.samples_per_frame = samples_per_frame;
  assign res_out.bitrate_kbps      = bitrate_kbps;

  // Checks
  `MAFHD_ASSERT_NOW(a_invalid_zero, res_out.valid && !res_out.valid_res,
    (res_out.srate_hz == 16'd0) && (res_out.frame_bytes == 12'd0) &&
    (res_out.samples_per_frame == 11'd0) && (res_out.bitrate_kbps == 9'd0),
    "illegal header result carries nonzero fields")
  `MAFHD_ASSERT_NOW(a_spf_legal, res_out.valid && res_out.valid_res,
    (res_out.samples_per_frame == mafhd_pkg::SpfL1) ||
    (res_out.samples_per_frame == mafhd_pkg::SpfL3Lsf) ||
    (res_out.samples_per_frame == mafhd_pkg::SpfFull),
    "samples per frame out of set")
  `MAFHD_ASSERT_NOW(a_l1_size_aligned,
    res_out.valid && res_out.valid_res && (res_out.samples_per_frame == mafhd_pkg::SpfL1),
    res_out.frame_bytes[1:0] == 2'b00, "layer 1 frame size not a slot multiple")
  `MAFHD_ASSERT_NEXT(a_in_to_stage0, hdr_in.valid && hdr_in.ready, stage_vld[0],
    "accepted header missing from first stage")

endmodule
`default_nettype wire

// File: sim/mpeg_audio_frame_header_decode_top_tb.sv
// Testbench for the MPEG audio frame header decoder: directed table, random headers, scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module mpeg_audio_frame_header_decode_top_tb;

  localparam int RandomHeaders = 1650;
  localparam int QuietTail     = 300;
  localparam int DrainCycles   = 20;

  // Bitrates in kbit/s, rows are layer 1, 2, 3
  localparam int unsigned KbpsMpeg1 [3][15] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320}};
  localparam int unsigned KbpsLsf [3][15] = '{
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}};

  typedef struct packed {
    logic        valid_res;
    logic [15:0] srate_hz;
    logic [11:0] frame_bytes;
    logic [10:0] samples_per_frame;
    logic [8:0]  bitrate_kbps;
  } decode_t;

  typedef struct {
    logic [23:0] header;
    bit          typed;     // use the typed decode instead of the predictor
    decode_t     decode;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mafhd_in_if  hdr_if ();
  mafhd_out_if res_if ();

  mpeg_audio_frame_header_decode_top dut (
    .clk     (clk),
    .rst     (rst),
    .hdr_in  (hdr_if),
    .res_out (res_if)
  );

  decode_t   expected_decodes[$];
  stim_row_t directed_rows[$];
  decode_t   oldest_decode;
  int        mismatches = 0;
  bit        quiet = 1'b0;
  bit        calm  = 1'b0;

  always #2 clk = ~clk;

  // Assemble a header word with sync bits set around the decoded fields
  function automatic logic [23:0] make_header(input logic [1:0] vcode, input logic [1:0] lcode,
                                              input logic [3:0] bidx, input logic [1:0] sidx,
                                              input logic pad);
    return {3'b111, vcode, lcode, 1'b1, bidx, sidx, pad, 1'b0, 8'h00};
  endfunction

  // Work out the decoded frame data of one header word
  function automatic decode_t decode_header(input logic [23:0] h);
    decode_t     d;
    logic [1:0]  vcode, lcode, sidx;
    logic [3:0]  bidx;
    int unsigned shift, row, kbps, rate, size;
    bit          lsf;
    d     = '0;
    vcode = h[20:19];
    lcode = h[18:17];
    bidx  = h[15:12];
    sidx  = h[11:10];
    if (lcode == mafhd_pkg::LcodeRsvd || sidx == mafhd_pkg::SidxRsvd ||
        bidx == mafhd_pkg::BidxBad) return d;
    // reserved version decodes as MPEG-2.5
    if (vcode == mafhd_pkg::VcodeMpeg1)      shift = 0;
    else if (vcode == mafhd_pkg::VcodeMpeg2) shift = 1;
    else                                     shift = 2;
    lsf  = (shift != 0);
    row  = 3 - lcode;
    kbps = lsf ? KbpsLsf[row][bidx] : KbpsMpeg1[row][bidx];
    case (sidx)
      2'd0:    rate = 32'(mafhd_pkg::Sr44k);
      2'd1:    rate = 32'(mafhd_pkg::Sr48k);
      default: rate = 32'(mafhd_pkg::Sr32k);
    endcase
    rate = rate >> shift;
    if (lcode == mafhd_pkg::LcodeL1) begin
      size = ((12000 * kbps) / rate + h[9]) * 4;
      d.samples_per_frame = mafhd_pkg::SpfL1;
    end else begin
      size = (144000 * kbps) / rate;
      if (lcode == mafhd_pkg::LcodeL3 && lsf) begin
        size = size >> 1;
        d.samples_per_frame = mafhd_pkg::SpfL3Lsf;
      end else begin
        d.samples_per_frame = mafhd_pkg::SpfFull;
      end
      size = size + h[9];
    end
    d.valid_res    = 1'b1;
    d.srate_hz     = rate[15:0];
    d.frame_bytes  = size[11:0];
    d.bitrate_kbps = kbps[8:0];
    return d;
  endfunction

  // Random header, mostly with legal layer, rate and bitrate codes
  function automatic logic [23:0] random_header();
    logic [23:0] h;
    h = 24'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      if (h[18:17] == mafhd_pkg::LcodeRsvd) h[18:17] = 2'($urandom_range(1, 3));
      if (h[11:10] == mafhd_pkg::SidxRsvd)  h[11:10] = 2'($urandom_range(0, 2));
      if (h[15:12] == mafhd_pkg::BidxBad)   h[15:12] = 4'($urandom_range(0, 14));
    end
    return h;
  endfunction

  // Offer one header, record its decode at the transfer, return at the next falling edge
  task automatic send_header(input logic [23:0] h, input decode_t want);
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      hdr_if.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    hdr_if.valid       = 1'b1;
    hdr_if.header_bits = h;
    @(posedge clk);
    while (!hdr_if.ready) @(posedge clk);
    expected_decodes.push_back(want);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: stall in random bursts
  initial begin
    int stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && !quiet && !calm && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 11);
      if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest decode waiting
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_decodes.size() == 0) begin
        $error("result transfer with no decode waiting");
        mismatches++;
      end else begin
        oldest_decode = expected_decodes.pop_front();
        check_field("valid_res", 32'(oldest_decode.valid_res), 32'(res_if.valid_res));
        check_field("srate_hz", 32'(oldest_decode.srate_hz), 32'(res_if.srate_hz));
        check_field("frame_bytes", 32'(oldest_decode.frame_bytes), 32'(res_if.frame_bytes));
        check_field("samples_per_frame", 32'(oldest_decode.samples_per_frame),
                    32'(res_if.samples_per_frame));
        check_field("bitrate_kbps", 32'(oldest_decode.bitrate_kbps),
                    32'(res_if.bitrate_kbps));
      end
    end
  end

  // Stimulus
  initial begin
    logic [23:0] h;
    hdr_if.valid       = 1'b0;
    hdr_if.header_bits = '0;

    // all-zero, all-one, reserved codes and free format
    directed_rows.push_back('{24'h000000, 1'b1, decode_t'('0)});
    directed_rows.push_back('{24'hFFFFFF, 1'b1, decode_t'('0)});
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg1, mafhd_pkg::LcodeRsvd, 4'd9,
                                          2'd0, 1'b1), 1'b1, decode_t'('0)});
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg1, mafhd_pkg::LcodeL3, 4'd9,
                                          mafhd_pkg::SidxRsvd, 1'b0), 1'b1, decode_t'('0)});
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg2, mafhd_pkg::LcodeL2,
                                          mafhd_pkg::BidxBad, 2'd1, 1'b1), 1'b1,
                              decode_t'('0)});
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg1, mafhd_pkg::LcodeL1, 4'd0,
                                          2'd0, 1'b1), 1'b1,
                              '{1'b1, 16'd44100, 12'd4, 11'd384, 9'd0}});
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg2, mafhd_pkg::LcodeL3, 4'd0,
                                          2'd1, 1'b0), 1'b1,
                              '{1'b1, 16'd24000, 12'd0, 11'd576, 9'd0}});
    // largest frame, largest bitrate
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg25, mafhd_pkg::LcodeL2, 4'd14,
                                          2'd2, 1'b1), 1'b1,
                              '{1'b1, 16'd8000, 12'd2881, 11'd1152, 9'd160}});
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg1, mafhd_pkg::LcodeL1, 4'd14,
                                          2'd2, 1'b1), 1'b1,
                              '{1'b1, 16'd32000, 12'd676, 11'd384, 9'd448}});
    // reserved version and the remaining layer and version pairs
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeRsvd, mafhd_pkg::LcodeL3, 4'd14,
                                          2'd1, 1'b1), 1'b0, '0});
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg1, mafhd_pkg::LcodeL3, 4'd9,
                                          2'd0, 1'b0), 1'b0, '0});
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg2, mafhd_pkg::LcodeL1, 4'd14,
                                          2'd1, 1'b1), 1'b0, '0});
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg25, mafhd_pkg::LcodeL3, 4'd14,
                                          2'd2, 1'b1), 1'b0, '0});
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg1, mafhd_pkg::LcodeL2, 4'd14,
                                          2'd1, 1'b0), 1'b0, '0});
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg1, mafhd_pkg::LcodeL3, 4'd1,
                                          2'd2, 1'b0), 1'b0, '0});
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg2, mafhd_pkg::LcodeL2, 4'd1,
                                          2'd0, 1'b1), 1'b0, '0});
    directed_rows.push_back('{make_header(mafhd_pkg::VcodeMpeg25, mafhd_pkg::LcodeL1, 4'd1,
                                          2'd0, 1'b0), 1'b0, '0});

    // hold reset, release at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_header(directed_rows[i].header,
                  directed_rows[i].typed ? directed_rows[i].decode
                                         : decode_header(directed_rows[i].header));

    // random headers, with calm stretches and a quiet tail
    for (int i = 0; i < RandomHeaders; i++) begin
      calm  = ((i / 80) % 3 == 2);
      quiet = (i >= RandomHeaders - QuietTail);
      h = random_header();
      send_header(h, decode_header(h));
    end
    hdr_if.valid = 1'b0;

    // drain
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_decodes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
